// File: hw/rtl/glyph_atlas_shelf_allocator_assert.svh
// ---------------------------------------------------------------------------
// Glyph atlas shelf allocator assertion macros
// Shared property forms for the allocator's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef GLYPH_ATLAS_SHELF_ALLOCATOR_ASSERT_SVH
`define GLYPH_ATLAS_SHELF_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define GAA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glyph atlas allocator check failed");

// next-cycle implication, disabled while reset is held
`define GAA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glyph atlas allocator check failed");

`endif

// File: hw/rtl/gaa_pkg.sv
// ---------------------------------------------------------------------------
// Glyph atlas allocator package
// Shared types and constants for the shelf allocator.
// ---------------------------------------------------------------------------
package gaa_pkg;

    localparam int unsigned DIM_W  = 11;   // glyph size, page side, shelf fields
    localparam int unsigned NEED_W = 12;   // padded size
    localparam int unsigned POS_W  = 10;
    localparam int unsigned PIDX_W = 3;

    localparam logic [NEED_W-1:0] PAD_PIXELS = 12'd1;
    localparam logic [DIM_W-1:0]  SIDE_RESET = 11'd256;
    localparam logic [DIM_W-1:0]  DIM_MAX    = 11'h7FF;

    typedef logic [DIM_W-1:0]  t_dim;
    typedef logic [NEED_W-1:0] t_need;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [PIDX_W-1:0] t_pidx;

    // one page's shelf state, as held in the shelf RAM
    typedef struct packed {
        t_dim cursor_x;
        t_dim top_y;
        t_dim height;
    } t_shelf;

    // outcome of checking one page
    typedef struct packed {
        logic   wr;     // entry changed (wrap and/or placement)
        logic   fit;    // rectangle placed on this page
        t_shelf upd;
        t_pos   px;
        t_pos   py;
    } t_shelf_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_SCAN,
        ST_FIN
    } t_state;

endpackage

// File: hw/rtl/gaa_intf.sv
// ---------------------------------------------------------------------------
// Glyph atlas allocator channels
// Valid/ready channels for glyph requests and placement results.
// ---------------------------------------------------------------------------
interface gaa_in_if;
    logic          valid;
    logic          ready;
    gaa_pkg::t_dim glyph_width;
    gaa_pkg::t_dim glyph_height;

    modport source (output valid, output glyph_width, output glyph_height, input ready);
    modport sink   (input valid, input glyph_width, input glyph_height, output ready);
endinterface

interface gaa_out_if;
    logic           valid;
    logic           ready;
    logic           placed;
    gaa_pkg::t_pidx page_index;
    gaa_pkg::t_pos  pos_x;
    gaa_pkg::t_pos  pos_y;
    logic           new_page;

    modport source (output valid, output placed, output page_index, output pos_x,
                    output pos_y, output new_page, input ready);
    modport sink   (input valid, input placed, input page_index, input pos_x,
                    input pos_y, input new_page, output ready);
endinterface

// File: hw/rtl/gaa_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module gaa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/gaa_shelf_eval.sv
// ---------------------------------------------------------------------------
// Shelf evaluator
// Wraps a page's shelf if needed and tests whether the rectangle fits.
// ---------------------------------------------------------------------------
module gaa_shelf_eval (
    input  gaa_pkg::t_shelf     i_shelf,
    input  gaa_pkg::t_need      i_need_w,
    input  gaa_pkg::t_need      i_need_h,
    input  gaa_pkg::t_dim       i_side,
    output gaa_pkg::t_shelf_res o_res
);
    import gaa_pkg::*;

    logic            wrap;
    logic [NEED_W-1:0] top_sum;
    t_dim            top_wrap;
    t_dim            cx1;
    t_dim            ty1;
    t_dim            h1;
    logic            fit;
    logic [NEED_W-1:0] cx_sum;
    t_dim            cx_new;
    t_dim            h_new;

    always_comb begin
        wrap     = ({2'b00, i_shelf.cursor_x} + {1'b0, i_need_w}) > {2'b00, i_side};
        top_sum  = {1'b0, i_shelf.top_y} + {1'b0, i_shelf.height};
        top_wrap = top_sum[NEED_W-1] ? DIM_MAX : top_sum[DIM_W-1:0];

        cx1 = wrap ? '0       : i_shelf.cursor_x;
        ty1 = wrap ? top_wrap : i_shelf.top_y;
        h1  = wrap ? '0       : i_shelf.height;

        fit = ({2'b00, ty1} + {1'b0, i_need_h}) <= {2'b00, i_side};

        // need sizes are at most page_side here, so they fit 11 bits
        cx_sum = {1'b0, cx1} + i_need_w;
        cx_new = cx_sum[NEED_W-1] ? DIM_MAX : cx_sum[DIM_W-1:0];
        h_new  = (i_need_h > {1'b0, h1}) ? i_need_h[DIM_W-1:0] : h1;

        o_res.wr  = wrap | fit;
        o_res.fit = fit;
        o_res.px  = cx1[POS_W-1:0];
        o_res.py  = ty1[POS_W-1:0];
        if (fit) begin
            o_res.upd = '{cursor_x: cx_new, top_y: ty1, height: h_new};
        end else begin
            o_res.upd = '{cursor_x: cx1, top_y: ty1, height: h1};
        end
    end
endmodule

// File: hw/rtl/glyph_atlas_shelf_allocator.sv
// ---------------------------------------------------------------------------
// Glyph atlas shelf allocator
// Shelf-packs padded glyph rectangles into up to MAX_PAGES square pages.
// ---------------------------------------------------------------------------
// Each request item carries a glyph width and height; both are padded by one
// pixel and placed by shelf packing. Open pages are tried in order, one page
// per cycle out of a single-port-read shelf RAM (cursor x, shelf top, shelf
// height per page). A rectangle that runs past a page's right edge wraps that
// page to a new shelf first, and the wrap is written back even if the page
// then turns out full. When no open page takes it, a new page is opened with
// the rectangle at its origin (new_page = 1). Failure (placed = 0, all other
// fields zero) comes when the padded size exceeds page_side or all pages are
// open. From acceptance an item passes through an issue state that starts the
// first RAM read, a scan of the open pages as the RAM streams entries (from
// one to MAX_PAGES pages, none on a size failure or with no page open), a
// finish state that waits for the output register to be free, and idle,
// where the next item is taken. A result sits in an output register, so a
// new item is taken while the last result waits. page_side is written through
// i_cfg_we/i_cfg_wdata, by the user only while idle (not enforced by the block)
// and resets to 256. The shelf RAM needs no clearing: only open pages are read.
// ---------------------------------------------------------------------------
module glyph_atlas_shelf_allocator #(
    parameter int unsigned MAX_PAGES = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  gaa_pkg::t_dim    i_cfg_wdata,
    gaa_in_if.sink           i_glyph,
    gaa_out_if.source        o_place
);
    import gaa_pkg::*;

    localparam int unsigned AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int unsigned PW = $clog2(MAX_PAGES + 1);
    localparam logic [PW-1:0] PAGES_MAX = PW'(MAX_PAGES);

    // control state
    t_state          r_state, n_state;
    t_dim            r_side;
    logic [PW-1:0]   r_pages, n_pages;
    logic [AW-1:0]   r_idx, n_idx;
    logic            r_found, n_found;
    logic            r_out_valid, n_out_valid;

    // item payload
    t_need           r_need_w, r_need_h;
    t_pos            r_px, n_px;
    t_pos            r_py, n_py;
    t_pidx           r_out_page, n_out_page;
    logic            r_out_placed, n_out_placed;
    t_pos            r_out_x, n_out_x;
    t_pos            r_out_y, n_out_y;
    logic            r_out_new, n_out_new;
    t_pidx           r_page, n_page;

    // shelf RAM
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    t_shelf          ram_wdata;
    logic [AW-1:0]   ram_raddr;
    t_shelf          ram_rdata;
    t_shelf_res      eval;

    logic            size_ok;
    logic            last_page;
    logic            out_free;
    logic            accept;

    gaa_ram #(
        .WIDTH ($bits(t_shelf)),
        .DEPTH (MAX_PAGES),
        .AW    (AW)
    ) u_shelf_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    gaa_shelf_eval u_eval (
        .i_shelf  (ram_rdata),
        .i_need_w (r_need_w),
        .i_need_h (r_need_h),
        .i_side   (r_side),
        .o_res    (eval)
    );

    assign accept    = i_glyph.valid & i_glyph.ready;
    assign size_ok   = (r_need_w <= {1'b0, r_side}) && (r_need_h <= {1'b0, r_side});
    assign last_page = (PW'(r_idx) + PW'(1)) == r_pages;
    assign out_free  = ~r_out_valid | o_place.ready;

    // page i+1 is read while page i is checked; entries never overlap
    assign ram_raddr = (r_state == ST_SCAN) ? AW'(r_idx + AW'(1)) : '0;

    assign i_glyph.ready      = (r_state == ST_IDLE);
    assign o_place.valid      = r_out_valid;
    assign o_place.placed     = r_out_placed;
    assign o_place.page_index = r_out_page;
    assign o_place.pos_x      = r_out_x;
    assign o_place.pos_y      = r_out_y;
    assign o_place.new_page   = r_out_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_side      <= SIDE_RESET;
            r_pages     <= '0;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pages     <= n_pages;
            r_idx       <= n_idx;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_side <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_need_w <= {1'b0, i_glyph.glyph_width} + PAD_PIXELS;
            r_need_h <= {1'b0, i_glyph.glyph_height} + PAD_PIXELS;
        end
        r_px         <= n_px;
        r_py         <= n_py;
        r_page       <= n_page;
        r_out_placed <= n_out_placed;
        r_out_page   <= n_out_page;
        r_out_x      <= n_out_x;
        r_out_y      <= n_out_y;
        r_out_new    <= n_out_new;
    end

    always_comb begin
        n_state      = r_state;
        n_pages      = r_pages;
        n_idx        = r_idx;
        n_found      = r_found;
        n_px         = r_px;
        n_py         = r_py;
        n_page       = r_page;
        n_out_valid  = r_out_valid & ~o_place.ready;
        n_out_placed = r_out_placed;
        n_out_page   = r_out_page;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_out_new    = r_out_new;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_wdata    = eval.upd;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                // RAM read of page 0 is under way
                n_found = 1'b0;
                n_idx   = '0;
                if (size_ok && (r_pages != '0)) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_SCAN: begin
                ram_we = eval.wr;
                if (eval.fit) begin
                    n_found = 1'b1;
                    n_px    = eval.px;
                    n_py    = eval.py;
                    n_page  = PIDX_W'(r_idx);
                    n_state = ST_FIN;
                end else if (last_page) begin
                    n_state = ST_FIN;
                end else begin
                    n_idx = AW'(r_idx + AW'(1));
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                    n_out_placed = 1'b0;
                    n_out_page   = '0;
                    n_out_x      = '0;
                    n_out_y      = '0;
                    n_out_new    = 1'b0;
                    if (r_found) begin
                        n_out_placed = 1'b1;
                        n_out_page   = r_page;
                        n_out_x      = r_px;
                        n_out_y      = r_py;
                    end else if (size_ok && (r_pages < PAGES_MAX)) begin
                        // open a new page with the rectangle at its origin
                        ram_we       = 1'b1;
                        ram_waddr    = AW'(r_pages);
                        ram_wdata    = '{cursor_x: r_need_w[DIM_W-1:0], top_y: '0,
                                         height: r_need_h[DIM_W-1:0]};
                        n_pages      = PW'(r_pages + PW'(1));
                        n_out_placed = 1'b1;
                        n_out_page   = PIDX_W'(r_pages);
                        n_out_new    = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`include "glyph_atlas_shelf_allocator_assert.svh"

    // open page count never passes the page limit
    `GAA_ASSERT_NOW(a_pages_bound, i_clk, i_rst_n, 1'b1, r_pages <= PAGES_MAX)
    // a fresh page result always reports a placement
    `GAA_ASSERT_NOW(a_new_implies_placed, i_clk, i_rst_n, r_out_valid && r_out_new, r_out_placed)
    // shelf RAM is only written while scanning or finishing an item
    `GAA_ASSERT_NOW(a_ram_we_state, i_clk, i_rst_n, ram_we,
        (r_state == ST_SCAN) || (r_state == ST_FIN))
    // page count moves only together with a new-page result
    `GAA_ASSERT_NEXT(a_pages_step, i_clk, i_rst_n, r_pages != n_pages,
        r_out_valid && r_out_new && (r_pages == $past(r_pages) + PW'(1)))

endmodule
